@@ rtl/spd_pkg.sv @@
package spd_pkg;

    localparam int unsigned MAX_PAYLOAD = 256;

    localparam logic [7:0] HEADER_FIRST_RESET  = 8'hEF;
    localparam logic [7:0] HEADER_SECOND_RESET = 8'h01;

    localparam logic [15:0] LENGTH_MIN = 16'd2;
    localparam logic [15:0] LENGTH_MAX = 16'(MAX_PAYLOAD + 2);

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_TIMEOUT  = 2'd2
    } status_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    localparam logic CFG_HEADER_FIRST  = 1'b0;
    localparam logic CFG_HEADER_SECOND = 1'b1;

    typedef enum logic [11:0] {
        PH_HUNT1 = 12'b0000_0000_0001,
        PH_HUNT2 = 12'b0000_0000_0010,
        PH_ADDR0 = 12'b0000_0000_0100,
        PH_ADDR1 = 12'b0000_0000_1000,
        PH_ADDR2 = 12'b0000_0001_0000,
        PH_ADDR3 = 12'b0000_0010_0000,
        PH_TYPE  = 12'b0000_0100_0000,
        PH_LENH  = 12'b0000_1000_0000,
        PH_LENL  = 12'b0001_0000_0000,
        PH_DATA  = 12'b0010_0000_0000,
        PH_CKH   = 12'b0100_0000_0000,
        PH_CKL   = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  rx_byte;
        logic [15:0] timeout_ticks;
    } spd_in_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  packet_type;
        logic [8:0]  payload_count;
        logic [1:0]  status;
    } spd_out_t;

endpackage

@@ rtl/sensor_packet_deframer_unit.sv @@
// Latency: a result is shown in the cycle after its item is accepted.
// Throughput: one item per cycle; the output register and the parser state
// update in the same cycle, so input ready stalls only while a result waits.
// Reset (rst_n low, asynchronous): header search, deadline disarmed, sum and
// counters cleared, header bytes back to 0xEF and 0x01, no result pending.
module sensor_packet_deframer_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  spd_pkg::spd_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output spd_pkg::spd_out_t out_data,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [7:0]       cfg_data
);
    import spd_pkg::*;

    logic [7:0]  header_first_reg;
    logic [7:0]  header_second_reg;

    phase_t      phase_reg, phase_next;
    logic [8:0]  seen_reg, seen_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  ck_high_reg, ck_high_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  len_high_reg, len_high_next;
    logic [8:0]  plen_reg, plen_next;
    logic [15:0] ticks_reg, ticks_next;
    logic        armed_reg, armed_next;

    logic        out_valid_reg;
    spd_out_t    out_reg;
    logic        emit;
    spd_out_t    emit_data;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] length;
    logic [15:0] ticks_dec;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign b         = in_data.rx_byte;
    assign length    = {len_high_reg, b};
    assign ticks_dec = (ticks_reg != 16'd0) ? ticks_reg - 16'd1 : 16'd0;

    always_comb
    begin
        phase_next    = phase_reg;
        seen_next     = seen_reg;
        sum_next      = sum_reg;
        ck_high_next  = ck_high_reg;
        type_next     = type_reg;
        len_high_next = len_high_reg;
        plen_next     = plen_reg;
        ticks_next    = ticks_reg;
        armed_next    = armed_reg;
        emit          = 1'b0;

        emit_data.result_kind   = KIND_END;
        emit_data.payload_byte  = 8'd0;
        emit_data.payload_index = 8'd0;
        emit_data.packet_type   = type_reg;
        emit_data.payload_count = 9'd0;
        emit_data.status        = STATUS_TIMEOUT;

        unique case (op_t'(in_data.operation))
            OP_START:
            begin
                phase_next = PH_HUNT1;
                seen_next  = 9'd0;
                sum_next   = 16'd0;
                ticks_next = in_data.timeout_ticks;
                if (in_data.timeout_ticks == 16'd0)
                begin
                    armed_next = 1'b0;
                    emit       = 1'b1;
                end
                else
                begin
                    armed_next = 1'b1;
                end
            end
            OP_BYTE:
            begin
                unique case (phase_reg)
                    PH_HUNT1:
                    begin
                        if (b == header_first_reg)
                            phase_next = PH_HUNT2;
                    end
                    PH_HUNT2:
                    begin
                        priority if (b == header_second_reg)
                            phase_next = PH_ADDR0;
                        else if (b != header_first_reg)
                            phase_next = PH_HUNT1;
                    end
                    PH_ADDR0: phase_next = PH_ADDR1;
                    PH_ADDR1: phase_next = PH_ADDR2;
                    PH_ADDR2: phase_next = PH_ADDR3;
                    PH_ADDR3:
                    begin
                        sum_next   = 16'd0;
                        seen_next  = 9'd0;
                        phase_next = PH_TYPE;
                    end
                    PH_TYPE:
                    begin
                        type_next  = b;
                        sum_next   = {8'd0, b};
                        phase_next = PH_LENH;
                    end
                    PH_LENH:
                    begin
                        len_high_next = b;
                        sum_next      = sum_reg + {8'd0, b};
                        phase_next    = PH_LENL;
                    end
                    PH_LENL:
                    begin
                        sum_next  = sum_reg + {8'd0, b};
                        plen_next = 9'(length - LENGTH_MIN);
                        if (length < LENGTH_MIN || length > LENGTH_MAX)
                        begin
                            phase_next = PH_HUNT1;
                        end
                        else
                        begin
                            seen_next  = 9'd0;
                            phase_next = (length > LENGTH_MIN) ? PH_DATA : PH_CKH;
                        end
                    end
                    PH_DATA:
                    begin
                        sum_next  = sum_reg + {8'd0, b};
                        seen_next = seen_reg + 9'd1;
                        emit      = 1'b1;
                        emit_data.result_kind   = KIND_PAYLOAD;
                        emit_data.payload_byte  = b;
                        emit_data.payload_index = seen_reg[7:0];
                        emit_data.payload_count = plen_reg;
                        emit_data.status        = STATUS_OK;
                        if (seen_next >= plen_reg)
                            phase_next = PH_CKH;
                    end
                    PH_CKH:
                    begin
                        ck_high_next = b;
                        phase_next   = PH_CKL;
                    end
                    PH_CKL:
                    begin
                        emit       = 1'b1;
                        armed_next = 1'b0;
                        phase_next = PH_HUNT1;
                        emit_data.payload_count = plen_reg;
                        emit_data.status = ({ck_high_reg, b} == sum_reg) ?
                                           STATUS_OK : STATUS_MISMATCH;
                    end
                    default: phase_next = PH_HUNT1;
                endcase
            end
            OP_TICK:
            begin
                if (armed_reg)
                begin
                    ticks_next = ticks_dec;
                    if (ticks_dec == 16'd0)
                    begin
                        armed_next = 1'b0;
                        phase_next = PH_HUNT1;
                        emit       = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HEADER_FIRST_RESET;
            header_second_reg <= HEADER_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                CFG_HEADER_SECOND: header_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT1;
            seen_reg      <= 9'd0;
            sum_reg       <= 16'd0;
            ck_high_reg   <= 8'd0;
            type_reg      <= 8'd0;
            len_high_reg  <= 8'd0;
            plen_reg      <= 9'd0;
            ticks_reg     <= 16'd0;
            armed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                seen_reg     <= seen_next;
                sum_reg      <= sum_next;
                ck_high_reg  <= ck_high_next;
                type_reg     <= type_next;
                len_high_reg <= len_high_next;
                plen_reg     <= plen_next;
                ticks_reg    <= ticks_next;
                armed_reg    <= armed_next;
            end
            if (in_ready)
                out_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            out_reg <= emit_data;
    end

`ifndef SYNTHESIS
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("parse phase not one-hot");

    a_armed_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> ticks_reg != 16'd0)
        else $error("deadline armed with no ticks left");

    a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.result_kind == KIND_PAYLOAD
        |-> out_reg.status == STATUS_OK && out_reg.payload_count != 9'd0)
        else $error("payload item with bad status or count");

    a_timeout_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == STATUS_TIMEOUT
        |-> out_reg.result_kind == KIND_END && out_reg.payload_count == 9'd0)
        else $error("timeout item with payload fields");

    a_end_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit && emit_data.result_kind == KIND_END |=> !armed_reg)
        else $error("deadline still armed after end item");
`endif

endmodule
